>>> src/log_line_field_locator_core_defines.svh
// Assertion macros for the log line field locator.
// Used by the port checker; no other dependencies.
`ifndef LOG_LINE_FIELD_LOCATOR_CORE_DEFINES_SVH
`define LOG_LINE_FIELD_LOCATOR_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LLFL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define LLFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/llfl_pkg.sv
// Shared types, character constants and the character classifier
// for the log line field locator. No dependencies.
package llfl_pkg;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D9    = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam logic [3:0] TLC_RESET = 4'd3;
	localparam logic [3:0] IDC_RESET = 4'd4;

	localparam logic REG_TLC = 1'b0;
	localparam logic REG_IDC = 1'b1;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic        pc_found;
		logic [11:0] pc_start;
		logic [11:0] pc_end;
		logic        hw_found;
		logic [11:0] hw_start;
		logic [11:0] hw_end;
		logic        bts_found;
		logic [11:0] bts_start;
		logic [11:0] bts_end;
		logic [12:0] line_length;
		logic        too_long;
	} res_item_t;

	typedef struct packed {
		logic digit;
		logic alpha;
		logic hex;
		logic lt;
		logic gt;
		logic dash;
		logic under;
		logic colon;
		logic dot;
		logic space;
	} chr_class_t;

	function automatic chr_class_t classify(input logic [7:0] c);
		chr_class_t r;
		r.digit = (c >= CH_D0) && (c <= CH_D9);
		r.alpha = ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
		r.hex   = r.digit || ((c >= CH_UA) && (c <= CH_UF)) || ((c >= CH_LA) && (c <= CH_LF));
		r.lt    = (c == CH_LT);
		r.gt    = (c == CH_GT);
		r.dash  = (c == CH_DASH);
		r.under = (c == CH_UNDER);
		r.colon = (c == CH_COLON);
		r.dot   = (c == CH_DOT);
		r.space = (c == CH_SPACE);
		return r;
	endfunction

endpackage

>>> src/llfl_front.sv
// Front end: accepts characters, classifies them and numbers their positions.
// Depends on llfl_pkg.
module llfl_front #(
	parameter int LINE_CAPACITY = 4096,
	localparam int PW = $clog2(LINE_CAPACITY),
	localparam int CW = $clog2(LINE_CAPACITY + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  llfl_pkg::in_item_t   item,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 q_full,
	output logic                 push,
	output llfl_pkg::chr_class_t cls,
	output logic                 last,
	output logic                 ovf,
	output logic [PW-1:0]        pos
);

	logic [CW-1:0] pos_q;

	assign item_ready = !q_full;
	assign push       = item_valid && item_ready;
	assign cls        = llfl_pkg::classify(item.ch);
	assign last       = item.last;
	assign ovf        = (pos_q >= CW'(LINE_CAPACITY));
	assign pos        = ovf ? PW'(LINE_CAPACITY - 1) : pos_q[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (item.last) begin
				pos_q <= '0;
			end else if (!ovf) begin
				pos_q <= pos_q + CW'(1);
			end
		end
	end

endmodule

>>> src/llfl_fifo.sv
// Short queue between the front end and the parser.
// No dependencies.
module llfl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

>>> src/llfl_back.sv
// Back end: field parser state machine and the result register.
// Depends on llfl_pkg.
module llfl_back #(
	parameter int LINE_CAPACITY = 4096,
	localparam int PW = $clog2(LINE_CAPACITY),
	localparam int CW = $clog2(LINE_CAPACITY + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [3:0]           tlc,
	input  logic [3:0]           idc,
	input  logic                 h_valid,
	input  llfl_pkg::chr_class_t h_cls,
	input  logic                 h_last,
	input  logic                 h_ovf,
	input  logic [PW-1:0]        h_pos,
	output logic                 pop,
	output llfl_pkg::res_item_t  res,
	output logic                 res_valid,
	input  logic                 res_ready
);

	localparam logic [3:0] ST_UNKNOWN    = 4'd0;
	localparam logic [3:0] ST_PC1        = 4'd1;
	localparam logic [3:0] ST_PC2        = 4'd2;
	localparam logic [3:0] ST_PC3        = 4'd3;
	localparam logic [3:0] ST_PC4        = 4'd4;
	localparam logic [3:0] ST_PC5        = 4'd5;
	localparam logic [3:0] ST_PC6        = 4'd6;
	localparam logic [3:0] ST_HW_LETTERS = 4'd7;
	localparam logic [3:0] ST_HW_DASH    = 4'd8;
	localparam logic [3:0] ST_HW_UNDER   = 4'd9;
	localparam logic [3:0] ST_HW_HEX     = 4'd10;
	localparam logic [3:0] ST_HW_ALNUM   = 4'd11;
	localparam logic [3:0] ST_BTS        = 4'd12;
	localparam logic [3:0] ST_STOP       = 4'd13;

	localparam int FB_PC  = 0;
	localparam int FB_HW  = 1;
	localparam int FB_BTS = 2;

	localparam int XW = 17;

	logic [3:0]    st_q, st_n;
	logic [3:0]    run_q, run_n;
	logic [2:0]    found_q, found_n;
	logic          ovf_q, ovf_n;
	logic [PW-1:0] pcs_q, pcs_n, pce_q, pce_n;
	logic [PW-1:0] hws_q, hws_n, hwe_q, hwe_n;
	logic [PW-1:0] btss_q, btss_n, btse_q, btse_n;
	logic [PW:0]   pos_p1;
	logic [PW-1:0] pos_p1_sat;
	logic [CW-1:0] len;
	logic          id_in_class;
	logic          res_valid_q;
	llfl_pkg::res_item_t res_q, res_n;

	function automatic logic [11:0] to12(input logic [PW-1:0] p);
		logic [XW-1:0] w;
		w = XW'(p);
		return w[11:0];
	endfunction

	assign pop       = h_valid && (!h_last || !res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign pos_p1     = {1'b0, h_pos} + (PW + 1)'(1);
	assign pos_p1_sat = (pos_p1 == (PW + 1)'(LINE_CAPACITY)) ? PW'(LINE_CAPACITY - 1)
	                                                         : pos_p1[PW-1:0];
	assign len         = h_ovf ? CW'(LINE_CAPACITY) : CW'(h_pos) + CW'(1);
	assign id_in_class = (st_q == ST_HW_HEX) ? h_cls.hex : (h_cls.alpha || h_cls.digit);

	always_comb begin
		logic [XW-1:0] len_w;
		st_n    = st_q;
		run_n   = run_q;
		found_n = found_q;
		ovf_n   = ovf_q || h_ovf;
		pcs_n   = pcs_q;
		pce_n   = pce_q;
		hws_n   = hws_q;
		hwe_n   = hwe_q;
		btss_n  = btss_q;
		btse_n  = btse_q;
		unique case (st_q)
			ST_UNKNOWN: begin
				if (!found_q[FB_PC] && h_cls.digit) begin
					st_n  = ST_PC1;
					pcs_n = h_pos;
				end else if (!found_q[FB_HW] && h_cls.alpha) begin
					st_n  = ST_HW_LETTERS;
					hws_n = h_pos;
					run_n = 4'd1;
				end else if (!found_q[FB_BTS] && h_cls.lt) begin
					st_n   = ST_BTS;
					btss_n = pos_p1_sat;
				end
			end
			ST_PC1: begin
				if (h_cls.dot) st_n = ST_PC2;
				else if (!h_cls.digit) st_n = ST_UNKNOWN;
			end
			ST_PC2: begin
				if (h_cls.space) st_n = ST_PC3;
				else if (!h_cls.digit) st_n = ST_UNKNOWN;
			end
			ST_PC3: begin
				if (h_cls.colon) st_n = ST_PC4;
				else if (!h_cls.digit) st_n = ST_UNKNOWN;
			end
			ST_PC4: begin
				if (h_cls.colon) st_n = ST_PC5;
				else if (!h_cls.digit) st_n = ST_UNKNOWN;
			end
			ST_PC5: begin
				if (h_cls.dot) st_n = ST_PC6;
				else if (!h_cls.digit) st_n = ST_UNKNOWN;
			end
			ST_PC6: begin
				if (!h_cls.digit) begin
					st_n           = ST_UNKNOWN;
					pce_n          = h_pos;
					found_n[FB_PC] = 1'b1;
				end
			end
			ST_HW_LETTERS: begin
				if (h_cls.dash && (run_q == tlc)) begin
					st_n = ST_HW_DASH;
				end else if (h_cls.under && (run_q == tlc)) begin
					st_n = ST_HW_UNDER;
				end else if (h_cls.alpha && (run_q < tlc)) begin
					run_n = run_q + 4'd1;
				end else begin
					st_n = ST_UNKNOWN;
				end
			end
			ST_HW_DASH: begin
				if (h_cls.hex) begin
					st_n  = ST_HW_HEX;
					run_n = 4'd1;
				end else begin
					st_n = ST_UNKNOWN;
				end
			end
			ST_HW_UNDER: begin
				if (h_cls.alpha || h_cls.digit) begin
					st_n  = ST_HW_ALNUM;
					run_n = 4'd1;
				end else begin
					st_n = ST_UNKNOWN;
				end
			end
			ST_HW_HEX, ST_HW_ALNUM: begin
				if (id_in_class) begin
					if (run_q < idc) run_n = run_q + 4'd1;
					else st_n = ST_UNKNOWN;
				end else begin
					st_n = ST_UNKNOWN;
					if (run_q == idc) begin
						hwe_n          = h_pos;
						found_n[FB_HW] = 1'b1;
					end
				end
			end
			ST_BTS: begin
				if (h_cls.gt) begin
					st_n            = ST_STOP;
					btse_n          = h_pos;
					found_n[FB_BTS] = 1'b1;
				end
			end
			ST_STOP: begin
			end
			default: begin
				st_n = ST_UNKNOWN;
			end
		endcase

		len_w             = XW'(len);
		res_n.pc_found    = found_n[FB_PC];
		res_n.pc_start    = found_n[FB_PC] ? to12(pcs_n) : 12'd0;
		res_n.pc_end      = found_n[FB_PC] ? to12(pce_n) : 12'd0;
		res_n.hw_found    = found_n[FB_HW];
		res_n.hw_start    = found_n[FB_HW] ? to12(hws_n) : 12'd0;
		res_n.hw_end      = found_n[FB_HW] ? to12(hwe_n) : 12'd0;
		res_n.bts_found   = found_n[FB_BTS];
		res_n.bts_start   = found_n[FB_BTS] ? to12(btss_n) : 12'd0;
		res_n.bts_end     = found_n[FB_BTS] ? to12(btse_n) : 12'd0;
		res_n.line_length = len_w[12:0];
		res_n.too_long    = ovf_n;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pcs_q  <= pcs_n;
			pce_q  <= pce_n;
			hws_q  <= hws_n;
			hwe_q  <= hwe_n;
			btss_q <= btss_n;
			btse_q <= btse_n;
			if (h_last) begin
				res_q <= res_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_UNKNOWN;
			run_q       <= '0;
			found_q     <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (h_last) begin
					st_q    <= ST_UNKNOWN;
					run_q   <= '0;
					found_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					st_q    <= st_n;
					run_q   <= run_n;
					found_q <= found_n;
					ovf_q   <= ovf_n;
				end
			end
			if (pop && h_last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/log_line_field_locator_core.sv
// A line's result is registered when the parser pops its last character, which waits
// behind older queued characters and behind a held result. Throughput: one character
// per cycle while the queue has room; a two-entry queue parts the classifier from the
// parser, and a result register lets the next line start while a result waits. Reset
// clears all control state at once and sets the count registers to 3 and 4.
// Top level: configuration registers, front end, queue and parser.
// Depends on llfl_pkg, llfl_front, llfl_fifo and llfl_back.
module log_line_field_locator_core #(
	parameter int LINE_CAPACITY = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  llfl_pkg::in_item_t  item,
	input  logic                item_valid,
	output logic                item_ready,
	output llfl_pkg::res_item_t res,
	output logic                res_valid,
	input  logic                res_ready
);

	localparam int PW    = $clog2(LINE_CAPACITY);
	localparam int EW    = $bits(llfl_pkg::chr_class_t) + 2 + PW;
	localparam int QUEUE = 2;

	logic [3:0]           tlc_q;
	logic [3:0]           idc_q;
	logic                 wr_en;
	logic                 push, pop, q_full, q_empty;
	llfl_pkg::chr_class_t f_cls, h_cls;
	logic                 f_last, f_ovf, h_last, h_ovf;
	logic [PW-1:0]        f_pos, h_pos;
	logic [EW-1:0]        q_wr, q_rd;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == llfl_pkg::REG_IDC) ? {28'd0, idc_q} : {28'd0, tlc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlc_q <= llfl_pkg::TLC_RESET;
			idc_q <= llfl_pkg::IDC_RESET;
		end else if (wr_en) begin
			if (paddr[2] == llfl_pkg::REG_TLC) tlc_q <= pwdata[3:0];
			else idc_q <= pwdata[3:0];
		end
	end

	llfl_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.q_full     (q_full),
		.push       (push),
		.cls        (f_cls),
		.last       (f_last),
		.ovf        (f_ovf),
		.pos        (f_pos)
	);

	assign q_wr = {f_cls, f_last, f_ovf, f_pos};

	llfl_fifo #(.WIDTH(EW), .DEPTH(QUEUE)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (q_wr),
		.pop     (pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign {h_cls, h_last, h_ovf, h_pos} = q_rd;

	llfl_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tlc       (tlc_q),
		.idc       (idc_q),
		.h_valid   (!q_empty),
		.h_cls     (h_cls),
		.h_last    (h_last),
		.h_ovf     (h_ovf),
		.h_pos     (h_pos),
		.pop       (pop),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

endmodule

>>> src/llfl_checker.sv
// Port-level checker for the log line field locator, bound to the top level.
// Depends on llfl_pkg and log_line_field_locator_core_defines.svh.
`include "log_line_field_locator_core_defines.svh"

module llfl_checker #(
	parameter int LINE_CAPACITY = 4096
) (
	input logic                clk,
	input logic                arst_n,
	input llfl_pkg::res_item_t res,
	input logic                res_valid,
	input logic                res_ready
);

	`LLFL_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(res), "stalled result changed")
	`LLFL_ASSERT(a_too_long_len, clk, arst_n, res_valid && res.too_long |-> res.line_length == 13'(LINE_CAPACITY), "overlong line has wrong length")
	`LLFL_ASSERT(a_pc_zero, clk, arst_n, res_valid && !res.pc_found |-> res.pc_start == 12'd0 && res.pc_end == 12'd0, "timestamp positions without a find")
	`LLFL_ASSERT(a_hw_bts_zero, clk, arst_n, res_valid && !res.hw_found && !res.bts_found |-> res.hw_end == 12'd0 && res.bts_end == 12'd0, "field end without a find")
	`LLFL_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !res_valid, "result valid during reset")

endmodule

bind log_line_field_locator_core llfl_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_llfl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res       (res),
	.res_valid (res_valid),
	.res_ready (res_ready)
);

>>> tb/log_line_field_locator_core_checker.sv
// Line summary checker for the log line field locator core.
// Watches the register port and both word channels, predicts each line's summary
// and compares it with the block's result. Depends on llfl_pkg.
module log_line_field_locator_core_checker #(
	parameter int LINE_CAPACITY = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	input  llfl_pkg::in_item_t  item,
	input  logic                item_valid,
	input  logic                item_ready,
	input  llfl_pkg::res_item_t res,
	input  logic                res_valid,
	input  logic                res_ready,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] SCAN_IDLE     = 4'd0;
	localparam logic [3:0] SCAN_PC_INT   = 4'd1;
	localparam logic [3:0] SCAN_PC_FRAC  = 4'd2;
	localparam logic [3:0] SCAN_PC_HOUR  = 4'd3;
	localparam logic [3:0] SCAN_PC_MIN   = 4'd4;
	localparam logic [3:0] SCAN_PC_SEC   = 4'd5;
	localparam logic [3:0] SCAN_PC_SUB   = 4'd6;
	localparam logic [3:0] SCAN_HW_TYPE  = 4'd7;
	localparam logic [3:0] SCAN_HW_DASH  = 4'd8;
	localparam logic [3:0] SCAN_HW_UNDER = 4'd9;
	localparam logic [3:0] SCAN_HW_HEX   = 4'd10;
	localparam logic [3:0] SCAN_HW_ALNUM = 4'd11;
	localparam logic [3:0] SCAN_BTS      = 4'd12;
	localparam logic [3:0] SCAN_DONE     = 4'd13;

	logic [3:0]  scan;
	int unsigned line_pos;
	logic [3:0]  run_len;
	logic [3:0]  type_len;
	logic [3:0]  id_len;
	bit          pc_seen;
	bit          hw_seen;
	bit          bts_seen;
	bit          overflow;
	logic [11:0] pc_s, pc_e, hw_s, hw_e, bts_s, bts_e;
	llfl_pkg::res_item_t line_summary_q[$];
	int          err_count = 0;
	int          results_seen = 0;

	function automatic bit is_digit(input logic [7:0] c);
		return (c >= llfl_pkg::CH_D0) && (c <= llfl_pkg::CH_D9);
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return ((c >= llfl_pkg::CH_UA) && (c <= llfl_pkg::CH_UZ)) ||
			((c >= llfl_pkg::CH_LA) && (c <= llfl_pkg::CH_LZ));
	endfunction

	function automatic bit is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= llfl_pkg::CH_UA) && (c <= llfl_pkg::CH_UF)) ||
			((c >= llfl_pkg::CH_LA) && (c <= llfl_pkg::CH_LF));
	endfunction

	function automatic int unsigned clip_pos(input int unsigned p);
		return (p > LINE_CAPACITY - 1) ? LINE_CAPACITY - 1 : p;
	endfunction

	function automatic logic [3:0] pc_next(input logic [3:0] cur, input logic [7:0] c,
			input logic [7:0] mark, input logic [3:0] nxt);
		if (c == mark) return nxt;
		if (is_digit(c)) return cur;
		return SCAN_IDLE;
	endfunction

	task automatic clear_line();
		scan = SCAN_IDLE;
		line_pos = 0;
		run_len = '0;
		pc_seen = 1'b0;
		hw_seen = 1'b0;
		bts_seen = 1'b0;
		overflow = 1'b0;
		pc_s = '0;
		pc_e = '0;
		hw_s = '0;
		hw_e = '0;
		bts_s = '0;
		bts_e = '0;
	endtask

	task automatic id_run_step(input bit in_class, input int unsigned pos);
		if (in_class) begin
			if (run_len < id_len) run_len = run_len + 4'd1;
			else scan = SCAN_IDLE;
		end else begin
			scan = SCAN_IDLE;
			if (run_len == id_len) begin
				hw_e = 12'(pos);
				hw_seen = 1'b1;
			end
		end
	endtask

	task automatic scan_char(input logic [7:0] c, input int unsigned pos);
		unique case (scan)
			SCAN_IDLE: begin
				if (!pc_seen && is_digit(c)) begin
					scan = SCAN_PC_INT;
					pc_s = 12'(pos);
				end else if (!hw_seen && is_alpha(c)) begin
					scan = SCAN_HW_TYPE;
					hw_s = 12'(pos);
					run_len = 4'd1;
				end else if (!bts_seen && c == llfl_pkg::CH_LT) begin
					scan = SCAN_BTS;
					bts_s = 12'(clip_pos(pos + 1));
				end
			end
			SCAN_PC_INT: scan = pc_next(scan, c, llfl_pkg::CH_DOT, SCAN_PC_FRAC);
			SCAN_PC_FRAC: scan = pc_next(scan, c, llfl_pkg::CH_SPACE, SCAN_PC_HOUR);
			SCAN_PC_HOUR: scan = pc_next(scan, c, llfl_pkg::CH_COLON, SCAN_PC_MIN);
			SCAN_PC_MIN: scan = pc_next(scan, c, llfl_pkg::CH_COLON, SCAN_PC_SEC);
			SCAN_PC_SEC: scan = pc_next(scan, c, llfl_pkg::CH_DOT, SCAN_PC_SUB);
			SCAN_PC_SUB: begin
				if (!is_digit(c)) begin
					scan = SCAN_IDLE;
					pc_e = 12'(pos);
					pc_seen = 1'b1;
				end
			end
			SCAN_HW_TYPE: begin
				if (c == llfl_pkg::CH_DASH && run_len == type_len) scan = SCAN_HW_DASH;
				else if (c == llfl_pkg::CH_UNDER && run_len == type_len) scan = SCAN_HW_UNDER;
				else if (is_alpha(c) && run_len < type_len) run_len = run_len + 4'd1;
				else scan = SCAN_IDLE;
			end
			SCAN_HW_DASH: begin
				if (is_hex(c)) begin
					scan = SCAN_HW_HEX;
					run_len = 4'd1;
				end else begin
					scan = SCAN_IDLE;
				end
			end
			SCAN_HW_UNDER: begin
				if (is_alpha(c) || is_digit(c)) begin
					scan = SCAN_HW_ALNUM;
					run_len = 4'd1;
				end else begin
					scan = SCAN_IDLE;
				end
			end
			SCAN_HW_HEX: id_run_step(is_hex(c), pos);
			SCAN_HW_ALNUM: id_run_step(is_alpha(c) || is_digit(c), pos);
			SCAN_BTS: begin
				if (c == llfl_pkg::CH_GT) begin
					scan = SCAN_DONE;
					bts_e = 12'(pos);
					bts_seen = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic take_char(input llfl_pkg::in_item_t w);
		int unsigned pos;
		llfl_pkg::res_item_t s;
		if (line_pos >= LINE_CAPACITY) begin
			overflow = 1'b1;
			pos = LINE_CAPACITY - 1;
		end else begin
			pos = line_pos;
			line_pos++;
		end
		if (!bts_seen) scan_char(w.ch, pos);
		if (w.last) begin
			s = '0;
			s.pc_found = pc_seen;
			s.hw_found = hw_seen;
			s.bts_found = bts_seen;
			if (pc_seen) begin
				s.pc_start = pc_s;
				s.pc_end = pc_e;
			end
			if (hw_seen) begin
				s.hw_start = hw_s;
				s.hw_end = hw_e;
			end
			if (bts_seen) begin
				s.bts_start = bts_s;
				s.bts_end = bts_e;
			end
			s.line_length = 13'(line_pos);
			s.too_long = overflow;
			line_summary_q.push_back(s);
			clear_line();
		end
	endtask

	task automatic check_field(input string name, input logic [12:0] want, input logic [12:0] got);
		if (got !== want) begin
			err_count++;
			if (err_count <= 10)
				$display("%0t ns: line %0d field %s expected %0d got %0d",
					$time, results_seen, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		llfl_pkg::res_item_t want;
		if (!arst_n) begin
			type_len = llfl_pkg::TLC_RESET;
			id_len = llfl_pkg::IDC_RESET;
			clear_line();
			line_summary_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {llfl_pkg::REG_TLC, 2'b00}) type_len = pwdata[3:0];
				else if (paddr == {llfl_pkg::REG_IDC, 2'b00}) id_len = pwdata[3:0];
			end
			if (res_valid && res_ready) begin
				results_seen++;
				if (line_summary_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t ns: result word with no line outstanding", $time);
				end else begin
					want = line_summary_q.pop_front();
					check_field("pc_found", 13'(want.pc_found), 13'(res.pc_found));
					check_field("pc_start", 13'(want.pc_start), 13'(res.pc_start));
					check_field("pc_end", 13'(want.pc_end), 13'(res.pc_end));
					check_field("hw_found", 13'(want.hw_found), 13'(res.hw_found));
					check_field("hw_start", 13'(want.hw_start), 13'(res.hw_start));
					check_field("hw_end", 13'(want.hw_end), 13'(res.hw_end));
					check_field("bts_found", 13'(want.bts_found), 13'(res.bts_found));
					check_field("bts_start", 13'(want.bts_start), 13'(res.bts_start));
					check_field("bts_end", 13'(want.bts_end), 13'(res.bts_end));
					check_field("line_length", want.line_length, res.line_length);
					check_field("too_long", 13'(want.too_long), 13'(res.too_long));
				end
			end
			if (item_valid && item_ready) take_char(item);
		end
		fail_count <= err_count;
		pending <= line_summary_q.size();
	end

endmodule

>>> tb/log_line_field_locator_core_tb.sv
// Top of the log line field locator core testbench: clock, reset, register
// writes, log line stimulus and the verdict. Depends on llfl_pkg, the core and
// log_line_field_locator_core_checker.
module log_line_field_locator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_CAP    = 4096;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	llfl_pkg::in_item_t  item = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	llfl_pkg::res_item_t res;
	logic        res_valid;
	logic        res_ready = 1'b0;
	int          fail_count;
	int          pending;

	bit          quiet = 1'b0;
	bit          hold_results = 1'b0;
	int          cycle_count = 0;
	int          chars_sent = 0;
	int          lines_sent = 0;
	int          settings_used = 1;
	int          tlc_now = llfl_pkg::TLC_RESET;
	int          idc_now = llfl_pkg::IDC_RESET;
	logic [7:0]  line_buf[$];

	log_line_field_locator_core #(.LINE_CAPACITY(LINE_CAP)) u_dut (.*);

	log_line_field_locator_core_checker #(.LINE_CAPACITY(LINE_CAP)) u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycle_count);
			$display("log_line_field_locator_core test failed");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_results) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end else begin
				res_ready <= quiet || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	function automatic logic [7:0] pick_digit();
		return llfl_pkg::CH_D0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_alpha();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? llfl_pkg::CH_UA + 8'(r) : llfl_pkg::CH_LA + 8'(r - 26);
	endfunction

	function automatic logic [7:0] pick_hex();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return llfl_pkg::CH_D0 + 8'(r);
		if (r < 16) return llfl_pkg::CH_UA + 8'(r - 10);
		return llfl_pkg::CH_LA + 8'(r - 16);
	endfunction

	function automatic logic [7:0] pick_alnum();
		return $urandom_range(0, 1) ? pick_digit() : pick_alpha();
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	task automatic add_digits(input int n);
		repeat (n) line_buf.push_back(pick_digit());
	endtask

	task automatic add_pc(input bit broken);
		logic [7:0] marks[5];
		int         cut;
		marks = '{llfl_pkg::CH_DOT, llfl_pkg::CH_SPACE, llfl_pkg::CH_COLON,
			llfl_pkg::CH_COLON, llfl_pkg::CH_DOT};
		cut = broken ? $urandom_range(0, 5) : 6;
		add_digits($urandom_range(1, 3));
		for (int i = 0; i < 5; i++) begin
			if (i == cut) line_buf.push_back(8'($urandom_range(0, 255)));
			else line_buf.push_back(marks[i]);
			add_digits($urandom_range(1, 3));
		end
		if (cut != 5) line_buf.push_back(llfl_pkg::CH_SPACE);
	endtask

	task automatic add_hw(input bit broken);
		int n_type;
		int n_id;
		bit dash;
		n_type = tlc_now;
		n_id = idc_now;
		dash = $urandom_range(0, 1);
		if (broken) begin
			if ($urandom_range(0, 1)) n_type = n_type + ($urandom_range(0, 1) ? 1 : -1);
			else n_id = n_id + ($urandom_range(0, 1) ? 1 : -1);
		end
		repeat (n_type) line_buf.push_back(pick_alpha());
		line_buf.push_back(dash ? llfl_pkg::CH_DASH : llfl_pkg::CH_UNDER);
		repeat (n_id) line_buf.push_back(dash ? pick_hex() : pick_alnum());
		line_buf.push_back(llfl_pkg::CH_SPACE);
	endtask

	task automatic add_bts(input bit broken);
		logic [7:0] c;
		line_buf.push_back(llfl_pkg::CH_LT);
		repeat ($urandom_range(0, 5)) begin
			do c = 8'($urandom_range(0, 255)); while (c == llfl_pkg::CH_GT);
			line_buf.push_back(c);
		end
		if (!broken) line_buf.push_back(llfl_pkg::CH_GT);
	endtask

	task automatic add_segment();
		int r;
		bit broken;
		r = $urandom_range(0, 99);
		broken = ($urandom_range(0, 99) < 20);
		if (r < 25) add_pc(broken);
		else if (r < 50) add_hw(broken);
		else if (r < 65) add_bts(broken);
		else if (r < 85) repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom_range(0, 255)));
		else line_buf.push_back(llfl_pkg::CH_SPACE);
	endtask

	task automatic push_char(input logic [7:0] c, input logic is_last);
		item <= '{ch: c, last: is_last};
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		chars_sent++;
		if (!quiet && $urandom_range(0, 99) < 12) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++) push_char(line_buf[i], i == line_buf.size() - 1);
		lines_sent++;
	endtask

	task automatic random_lines(input int min_chars, input int min_lines);
		int first_char;
		int n_lines;
		first_char = chars_sent;
		n_lines = 0;
		while (chars_sent - first_char < min_chars || n_lines < min_lines) begin
			line_buf.delete();
			repeat ($urandom_range(1, 4)) add_segment();
			send_line();
			n_lines++;
		end
	endtask

	task automatic short_lines(input int n);
		repeat (n) begin
			line_buf.delete();
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 2))
					0: line_buf.push_back(llfl_pkg::CH_LT);
					1: line_buf.push_back(llfl_pkg::CH_GT);
					default: line_buf.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			send_line();
		end
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic configure(input int tlc, input int idc);
		settle();
		write_reg({llfl_pkg::REG_TLC, 2'b00}, 32'(tlc));
		write_reg({llfl_pkg::REG_IDC, 2'b00}, 32'(idc));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tlc_now = tlc;
		idc_now = idc;
		settings_used++;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// All three fields; the letter that ends the timestamp must not open an address.
		line_buf.delete();
		add_text("1.2 3:4:5.6AbZw_09aF <q>");
		send_line();
		line_buf.delete();
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		add_text("7.8 9");
		send_line();

		configure(0, 0);
		line_buf.delete();
		add_text("Ab-1 c_2");
		send_line();

		configure(1, 1);
		random_lines(150, 8);

		quiet = 1'b1;
		configure(15, 15);
		random_lines(150, 8);
		quiet = 1'b0;

		configure($urandom_range(1, 15), $urandom_range(1, 15));
		hold_results = 1'b1;
		short_lines(30);
		random_lines(150, 8);

		configure(15, 1);
		random_lines(150, 8);

		settle();
		repeat (10) @(posedge clk);
		$display("Sent %0d characters in %0d lines across %0d register settings,",
			chars_sent, lines_sent, settings_used);
		$display("with a full-speed stretch and a long result back-pressure stretch.");
		if (fail_count == 0 && pending == 0) begin
			$display("log_line_field_locator_core test passed");
		end else begin
			$display("log_line_field_locator_core test failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/llfl_pkg.sv
src/llfl_front.sv
src/llfl_fifo.sv
src/llfl_back.sv
src/log_line_field_locator_core.sv
src/llfl_checker.sv
tb/log_line_field_locator_core_checker.sv
tb/log_line_field_locator_core_tb.sv
